// ===== design/sam_pkg.sv =====
// ----------------------------------------------------------------------------
// sam_pkg
// Shared constants and types for the suffix automaton append core.
// ----------------------------------------------------------------------------
package sam_pkg;

   // Default sizing of the state store.
   localparam int MAX_STATES_DEF = 1024;
   localparam int ALPHABET_DEF   = 27;

   // Fixed widths of the item fields.
   localparam int SYMBOL_W    = 5;
   localparam int LEN_W       = 9;
   localparam int STATE_OUT_W = 10;

   // The longest length that a state may record.
   localparam logic [LEN_W-1:0] LEN_LIMIT = 9'd511;

   // Root state index; index zero means no state.
   localparam int ROOT = 1;

   // Write enables of the three state memories.
   typedef struct packed {
      logic len_we;
      logic link_we;
      logic row_we;
   } mem_we_type;

   // Sequencer states.
   typedef enum logic [12:0] {
      S_INIT  = 13'b0000000000001,
      S_IDLE  = 13'b0000000000010,
      S_WIPE  = 13'b0000000000100,
      S_CHK   = 13'b0000000001000,
      S_CHK2  = 13'b0000000010000,
      S_WALK  = 13'b0000000100000,
      S_LENP  = 13'b0000001000000,
      S_LENQ  = 13'b0000010000000,
      S_CLONE = 13'b0000100000000,
      S_REDIR = 13'b0001000000000,
      S_FIXQ  = 13'b0010000000000,
      S_FIXC  = 13'b0100000000000,
      S_RESP  = 13'b1000000000000
   } seq_state_type;

endpackage

// ===== design/sam_if.sv =====
// ----------------------------------------------------------------------------
// sam_req_if / sam_rsp_if
// Valid/ready channels carrying append requests and their results.
// ----------------------------------------------------------------------------
interface sam_req_if;
   import sam_pkg::*;
   logic                valid;
   logic                ready;
   logic                restart;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, output restart, output symbol, input ready);
   modport sink (input valid, input restart, input symbol, output ready);
endinterface

interface sam_rsp_if;
   import sam_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [STATE_OUT_W-1:0] end_state;
   logic [LEN_W-1:0]       end_length;
   logic [STATE_OUT_W-1:0] end_link;
   logic                   cloned;
   logic [STATE_OUT_W-1:0] clone_state;
   logic                   overflow;

   modport source (output valid, output end_state, output end_length, output end_link,
                   output cloned, output clone_state, output overflow, input ready);
   modport sink (input valid, input end_state, input end_length, input end_link,
                 input cloned, input clone_state, input overflow, output ready);
endinterface

// ===== design/sam_store.sv =====
// ----------------------------------------------------------------------------
// sam_store
// Length, suffix link and transition row memories of the automaton. Each
// memory has one write port and one registered read port.
// ----------------------------------------------------------------------------
module sam_store
   import sam_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEF,
   parameter int ALPHABET   = ALPHABET_DEF,
   localparam int SW = $clog2(MAX_STATES),
   localparam int RW = ALPHABET * SW
) (
   input  logic             clock,
   input  mem_we_type       we,
   input  logic [SW-1:0]    len_waddr,
   input  logic [LEN_W-1:0] len_wdata,
   input  logic [SW-1:0]    link_waddr,
   input  logic [SW-1:0]    link_wdata,
   input  logic [SW-1:0]    row_waddr,
   input  logic [RW-1:0]    row_wdata,
   input  logic [SW-1:0]    len_raddr,
   input  logic [SW-1:0]    lr_raddr,
   output logic [LEN_W-1:0] len_rdata,
   output logic [SW-1:0]    link_rdata,
   output logic [RW-1:0]    row_rdata
);

   logic [LEN_W-1:0] len_mem  [MAX_STATES];
   logic [SW-1:0]    link_mem [MAX_STATES];
   logic [RW-1:0]    row_mem  [MAX_STATES];

   // Lengths.
   always_ff @(posedge clock) begin
      if (we.len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rdata <= len_mem[len_raddr];
   end

   // Suffix links.
   always_ff @(posedge clock) begin
      if (we.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rdata <= link_mem[lr_raddr];
   end

   // Transition rows, one whole row per entry.
   always_ff @(posedge clock) begin
      if (we.row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_rdata <= row_mem[lr_raddr];
   end

endmodule

// ===== design/suffix_automaton_append_core.sv =====
// ----------------------------------------------------------------------------
// suffix_automaton_append_core
// Online suffix automaton builder, one appended symbol per item.
// ----------------------------------------------------------------------------
// An accepted item passes through S_CHK and S_CHK2, then S_WALK sets the
// missing transition of one state per step. When the walk meets an existing
// transition, S_LENP and S_LENQ fetch the two lengths. A split adds S_CLONE,
// S_REDIR with one step per redirected state and one more when the redirect
// walk stops at a transition that points elsewhere, then S_FIXQ and S_FIXC.
// A restart adds S_WIPE. An item with a symbol outside the alphabet leaves
// from S_CHK, and a refused item from S_CHK2, straight for S_RESP.
// The pace is set by the registered read ports of the state memories: every
// step of a suffix link walk needs one registered row and link read. After
// reset the root entry is written in S_INIT before the first item is taken. The
// result is held until it is taken, and no new item is accepted meanwhile.
// States beyond the highest one in use are never read before they are
// written, so a restart only rewrites the root.
module suffix_automaton_append_core
   import sam_pkg::*;
#(
   parameter int MAX_STATES = MAX_STATES_DEF,
   parameter int ALPHABET   = ALPHABET_DEF
) (
   input logic           clock,
   input logic           reset,
   sam_req_if.sink       req_ch,
   sam_rsp_if.source     rsp_ch
);

   localparam int SW = $clog2(MAX_STATES);
   localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
   localparam int RW = ALPHABET * SW;

   seq_state_type state_ff, state_in;

   logic                restart_ff, restart_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic [SW-1:0]       count_ff, count_in;
   logic [SW-1:0]       last_ff, last_in;
   logic [SW-1:0]       cur_ff, cur_in;
   logic [SW-1:0]       p_ff, p_in;
   logic [SW-1:0]       q_ff, q_in;
   logic [SW-1:0]       cl_ff, cl_in;
   logic [LEN_W-1:0]    curlen_ff, curlen_in;
   logic [LEN_W-1:0]    lenp_ff, lenp_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATE_OUT_W-1:0] end_state_ff, end_state_in;
   logic [LEN_W-1:0]       end_length_ff, end_length_in;
   logic [STATE_OUT_W-1:0] end_link_ff, end_link_in;
   logic                   cloned_ff, cloned_in;
   logic [STATE_OUT_W-1:0] clone_state_ff, clone_state_in;
   logic                   overflow_ff, overflow_in;

   mem_we_type       we;
   logic [SW-1:0]    len_waddr, link_waddr, row_waddr, len_raddr, lr_raddr;
   logic [SW-1:0]    link_wdata;
   logic [LEN_W-1:0] len_wdata;
   logic [RW-1:0]    row_wdata;
   logic [LEN_W-1:0] len_rdata;
   logic [SW-1:0]    link_rdata;
   logic [RW-1:0]    row_rdata;

   logic [AW-1:0]    sym_idx;
   logic [SW-1:0]    row_q;
   logic [SW-1:0]    patch_val;
   logic [RW-1:0]    row_patched;

   sam_store #(
      .MAX_STATES(MAX_STATES),
      .ALPHABET  (ALPHABET)
   ) u_store (
      .clock     (clock),
      .we        (we),
      .len_waddr (len_waddr),
      .len_wdata (len_wdata),
      .link_waddr(link_waddr),
      .link_wdata(link_wdata),
      .row_waddr (row_waddr),
      .row_wdata (row_wdata),
      .len_raddr (len_raddr),
      .lr_raddr  (lr_raddr),
      .len_rdata (len_rdata),
      .link_rdata(link_rdata),
      .row_rdata (row_rdata)
   );

   // Transition on the current symbol, and the row with that entry replaced.
   assign sym_idx = AW'(sym_ff);
   assign row_q   = row_rdata[sym_idx*SW +: SW];

   always_comb begin
      for (int i = 0; i < ALPHABET; i++) begin
         row_patched[i*SW +: SW] = (AW'(i) == sym_idx) ? patch_val : row_rdata[i*SW +: SW];
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      restart_in     = restart_ff;
      sym_in         = sym_ff;
      count_in       = count_ff;
      last_in        = last_ff;
      cur_in         = cur_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      cl_in          = cl_ff;
      curlen_in      = curlen_ff;
      lenp_in        = lenp_ff;
      rsp_valid_in   = rsp_valid_ff;
      end_state_in   = end_state_ff;
      end_length_in  = end_length_ff;
      end_link_in    = end_link_ff;
      cloned_in      = cloned_ff;
      clone_state_in = clone_state_ff;
      overflow_in    = overflow_ff;
      we             = '0;
      len_waddr      = cur_ff;
      len_wdata      = curlen_ff;
      link_waddr     = cur_ff;
      link_wdata     = '0;
      row_waddr      = p_ff;
      row_wdata      = row_patched;
      len_raddr      = last_ff;
      lr_raddr       = p_ff;
      patch_val      = cur_ff;

      unique case (state_ff)
         S_INIT, S_WIPE: begin
            // Rewrite the root as an empty state.
            we         = '{len_we: 1'b1, link_we: 1'b1, row_we: 1'b1};
            len_waddr  = SW'(ROOT);
            len_wdata  = '0;
            link_waddr = SW'(ROOT);
            row_waddr  = SW'(ROOT);
            row_wdata  = '0;
            count_in   = SW'(ROOT);
            last_in    = SW'(ROOT);
            state_in   = (state_ff == S_INIT) ? S_IDLE : S_CHK;
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               restart_in = req_ch.restart;
               sym_in     = req_ch.symbol;
               state_in   = req_ch.restart ? S_WIPE : S_CHK;
            end
         end
         S_CHK: begin
            // Fetch the length of the last state.
            len_raddr = last_ff;
            if (32'(sym_ff) >= 32'(ALPHABET)) begin
               end_state_in   = '0;
               end_length_in  = '0;
               end_link_in    = '0;
               cloned_in      = 1'b0;
               clone_state_in = '0;
               overflow_in    = 1'b0;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               state_in = S_CHK2;
            end
         end
         S_CHK2: begin
            if ((32'(count_ff) + 32'd2 > 32'(MAX_STATES - 1)) || (len_rdata >= LEN_LIMIT)) begin
               end_state_in   = '0;
               end_length_in  = '0;
               end_link_in    = '0;
               cloned_in      = 1'b0;
               clone_state_in = '0;
               overflow_in    = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               // Create the new state with an empty row.
               we        = '{len_we: 1'b1, link_we: 1'b0, row_we: 1'b1};
               len_waddr = count_ff + SW'(1);
               len_wdata = len_rdata + LEN_W'(1);
               row_waddr = count_ff + SW'(1);
               row_wdata = '0;
               cur_in    = count_ff + SW'(1);
               count_in  = count_ff + SW'(1);
               curlen_in = len_rdata + LEN_W'(1);
               p_in      = last_ff;
               lr_raddr  = last_ff;
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (row_q != '0) begin
               q_in      = row_q;
               len_raddr = p_ff;
               state_in  = S_LENP;
            end else begin
               // Set the missing transition and follow the suffix link.
               we        = '{len_we: 1'b0, link_we: 1'b0, row_we: 1'b1};
               patch_val = cur_ff;
               row_waddr = p_ff;
               p_in      = link_rdata;
               lr_raddr  = link_rdata;
               if (link_rdata == '0) begin
                  we.link_we     = 1'b1;
                  link_waddr     = cur_ff;
                  link_wdata     = SW'(ROOT);
                  last_in        = cur_ff;
                  end_state_in   = STATE_OUT_W'(cur_ff);
                  end_length_in  = curlen_ff;
                  end_link_in    = STATE_OUT_W'(ROOT);
                  cloned_in      = 1'b0;
                  clone_state_in = '0;
                  overflow_in    = 1'b0;
                  rsp_valid_in   = 1'b1;
                  state_in       = S_RESP;
               end
            end
         end
         S_LENP: begin
            lenp_in   = len_rdata;
            len_raddr = q_ff;
            state_in  = S_LENQ;
         end
         S_LENQ: begin
            if (lenp_ff + LEN_W'(1) == len_rdata) begin
               // Solid edge: link straight to the target.
               we             = '{len_we: 1'b0, link_we: 1'b1, row_we: 1'b0};
               link_waddr     = cur_ff;
               link_wdata     = q_ff;
               last_in        = cur_ff;
               end_state_in   = STATE_OUT_W'(cur_ff);
               end_length_in  = curlen_ff;
               end_link_in    = STATE_OUT_W'(q_ff);
               cloned_in      = 1'b0;
               clone_state_in = '0;
               overflow_in    = 1'b0;
               rsp_valid_in   = 1'b1;
               state_in       = S_RESP;
            end else begin
               // Split: allocate the clone and fetch the target's row.
               we        = '{len_we: 1'b1, link_we: 1'b0, row_we: 1'b0};
               len_waddr = count_ff + SW'(1);
               len_wdata = lenp_ff + LEN_W'(1);
               cl_in     = count_ff + SW'(1);
               count_in  = count_ff + SW'(1);
               lr_raddr  = q_ff;
               state_in  = S_CLONE;
            end
         end
         S_CLONE: begin
            we         = '{len_we: 1'b0, link_we: 1'b1, row_we: 1'b1};
            row_waddr  = cl_ff;
            row_wdata  = row_rdata;
            link_waddr = cl_ff;
            link_wdata = link_rdata;
            lr_raddr   = p_ff;
            state_in   = S_REDIR;
         end
         S_REDIR: begin
            if (row_q == q_ff) begin
               // Redirect this transition to the clone.
               we        = '{len_we: 1'b0, link_we: 1'b0, row_we: 1'b1};
               patch_val = cl_ff;
               row_waddr = p_ff;
               p_in      = link_rdata;
               lr_raddr  = link_rdata;
               if (link_rdata == '0) begin
                  state_in = S_FIXQ;
               end
            end else begin
               state_in = S_FIXQ;
            end
         end
         S_FIXQ: begin
            we         = '{len_we: 1'b0, link_we: 1'b1, row_we: 1'b0};
            link_waddr = q_ff;
            link_wdata = cl_ff;
            state_in   = S_FIXC;
         end
         S_FIXC: begin
            we             = '{len_we: 1'b0, link_we: 1'b1, row_we: 1'b0};
            link_waddr     = cur_ff;
            link_wdata     = cl_ff;
            last_in        = cur_ff;
            end_state_in   = STATE_OUT_W'(cur_ff);
            end_length_in  = curlen_ff;
            end_link_in    = STATE_OUT_W'(cl_ff);
            cloned_in      = 1'b1;
            clone_state_in = STATE_OUT_W'(cl_ff);
            overflow_in    = 1'b0;
            rsp_valid_in   = 1'b1;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
         count_ff     <= SW'(ROOT);
         last_ff      <= SW'(ROOT);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      restart_ff     <= restart_in;
      sym_ff         <= sym_in;
      cur_ff         <= cur_in;
      p_ff           <= p_in;
      q_ff           <= q_in;
      cl_ff          <= cl_in;
      curlen_ff      <= curlen_in;
      lenp_ff        <= lenp_in;
      end_state_ff   <= end_state_in;
      end_length_ff  <= end_length_in;
      end_link_ff    <= end_link_in;
      cloned_ff      <= cloned_in;
      clone_state_ff <= clone_state_in;
      overflow_ff    <= overflow_in;
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.end_state   = end_state_ff;
   assign rsp_ch.end_length  = end_length_ff;
   assign rsp_ch.end_link    = end_link_ff;
   assign rsp_ch.cloned      = cloned_ff;
   assign rsp_ch.clone_state = clone_state_ff;
   assign rsp_ch.overflow    = overflow_ff;

   // Checks.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input taken while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(MAX_STATES - 1))
      else $error("state count beyond the store");

   a_overflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.overflow) |-> (rsp_ch.end_state == '0 && !rsp_ch.cloned))
      else $error("refused item reports a state");

   a_clone_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.cloned) |-> (rsp_ch.clone_state == rsp_ch.end_link))
      else $error("clone is not the new state's link");

   a_wipe_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIPE) |-> restart_ff)
      else $error("root rewritten without a restart");

endmodule
